// ===== hw/rtl/spde_pkg.sv =====
// package for the shortest path distance engine
// constants, request kinds and status codes; no dependencies
package spde_pkg;
  localparam int NODE_LIMIT_D     = 64;
  localparam int EDGE_LIMIT_D     = 256;
  localparam int FACILITY_LIMIT_D = 16;
  localparam int WEIGHT_BITS_D    = 16;

  localparam int NODE_W   = 6;
  localparam int KIND_W   = 3;
  localparam int WIN_W    = 16;
  localparam int LEN_W    = 24;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 7;
  localparam int DIST_W   = 32;

  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FAC     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIST    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEAREST = 3'd4;

  localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNREACH = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef logic [DIST_W-1:0] dist_t;
endpackage

// ===== hw/rtl/shortest_path_distance_engine_unit.sv =====
// top level of the shortest path distance engine
// edge store, facility list, linear-scan dijkstra sequencer; uses spde_pkg
//
//  channel | dir | tdata fields (low bit first)              | tuser
//  in_     | in  | kind[2:0] node_a[8:3] node_b[14:9]        | -
//          |     | weight[30:15], zero pad to 32              |
//  out_    | out | status[1:0] path_length[25:2]              | -
//          |     | nearest_node[31:26] loads_dropped[32], pad |
//  cfg_    | in  | node_count[6:0], pad to 8                  | -
//
// loads and clears can follow back to back; in a query one compare unit scans nodes, one
// adder relaxes edges, and each edge passes through the EREQ, EDGE and RELX states for its
// memory and distance reads. a bad node index or an empty facility list goes straight to
// the done state without a search.
// reset (rst_n low, synchronous) empties the tables and sets node_count to 64.
// a finished result waits in the output register until out_tready; only a second finished
// result stalls, holding the sequencer in its last state and the input blocked.
module shortest_path_distance_engine_unit #(
  parameter int EDGE_LIMIT     = spde_pkg::EDGE_LIMIT_D,
  parameter int FACILITY_LIMIT = spde_pkg::FACILITY_LIMIT_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // kind, node_a, node_b, weight
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status, path_length, nearest_node, loads_dropped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // node_count
);
  import spde_pkg::*;

  localparam int NODE_LIMIT  = NODE_LIMIT_D;
  localparam int WEIGHT_BITS = WEIGHT_BITS_D;

  localparam int NI_W = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;
  localparam int NC_W = $clog2(NODE_LIMIT + 1);
  localparam int EI_W = (EDGE_LIMIT > 1) ? $clog2(EDGE_LIMIT) : 1;
  localparam int EC_W = $clog2(EDGE_LIMIT + 1);
  localparam int FI_W = (FACILITY_LIMIT > 1) ? $clog2(FACILITY_LIMIT) : 1;
  localparam int FC_W = $clog2(FACILITY_LIMIT + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_PICK = 4'd3;
  localparam logic [3:0] S_EREQ = 4'd4;
  localparam logic [3:0] S_EDGE = 4'd5;
  localparam logic [3:0] S_RELX = 4'd6;
  localparam logic [3:0] S_FREQ = 4'd7;
  localparam logic [3:0] S_FAC  = 4'd8;
  localparam logic [3:0] S_DREQ = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // request fields
  logic [KIND_W-1:0] in_kind;
  logic [NODE_W-1:0] in_a, in_b;
  logic [WIN_W-1:0]  in_w;
  assign in_kind = in_tdata[2:0];
  assign in_a    = in_tdata[8:3];
  assign in_b    = in_tdata[14:9];
  assign in_w    = in_tdata[30:15];

  // stores
  logic [NODE_W-1:0]      esrc_mem [EDGE_LIMIT];
  logic [NODE_W-1:0]      edst_mem [EDGE_LIMIT];
  logic [WEIGHT_BITS-1:0] elen_mem [EDGE_LIMIT];
  logic [NODE_W-1:0]      fac_mem  [FACILITY_LIMIT];
  dist_t                  dist_mem [NODE_LIMIT];
  logic [NODE_LIMIT-1:0]  reached_r, settled_r;

  logic [3:0]      state_r;
  logic [CNT_W-1:0] node_count_r;
  logic [EC_W-1:0] edges_r;
  logic [FC_W-1:0] facs_r;
  logic            dropped_r;
  logic [KIND_W-1:0] kind_r;
  logic [NODE_W-1:0] a_r, b_r;
  logic [NC_W-1:0] n_r;
  logic [NC_W-1:0] scan_r;   // node scan index
  logic [EC_W-1:0] eidx_r;
  logic [FC_W-1:0] fidx_r;
  logic            any_r;
  logic [NI_W-1:0] cur_r;
  dist_t           best_r, curd_r;
  logic [NODE_W-1:0] best_node_r;

  // registered memory read data
  logic [NODE_W-1:0]      rd_src_r, rd_dst_r, rd_fac_r;
  logic [WEIGHT_BITS-1:0] rd_len_r;
  dist_t                  rd_dist_r;
  logic [NI_W-1:0]        dist_raddr;
  logic                   dist_we;
  logic [NI_W-1:0]        dist_waddr;
  dist_t                  dist_wdata;

  // working result fields
  logic [STAT_W-1:0] o_stat_r;
  logic [LEN_W-1:0]  o_len_r;
  logic [NODE_W-1:0] o_node_r;

  // output register
  logic out_valid_r;
  logic [STAT_W-1:0] out_stat_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [NODE_W-1:0] out_node_r;
  logic              out_drop_r;

  logic done_go;
  assign done_go = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_drop_r, out_node_r, out_len_r, out_stat_r};

  // active node count, clamped
  logic [NC_W-1:0] n_act;
  always_comb begin
    if (node_count_r == '0) n_act = NC_W'(1);
    else if ({{(32-CNT_W){1'b0}}, node_count_r} > NODE_LIMIT) n_act = NC_W'(NODE_LIMIT);
    else n_act = NC_W'(node_count_r);
  end

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // memory writes and reads
  always_ff @(posedge clk) begin
    if (in_fire && in_kind == KIND_EDGE && edges_r < EC_W'(EDGE_LIMIT)) begin
      esrc_mem[edges_r[EI_W-1:0]] <= in_a;
      edst_mem[edges_r[EI_W-1:0]] <= in_b;
      elen_mem[edges_r[EI_W-1:0]] <= in_w[WEIGHT_BITS-1:0];
    end
    if (in_fire && in_kind == KIND_FAC && facs_r < FC_W'(FACILITY_LIMIT))
      fac_mem[facs_r[FI_W-1:0]] <= in_a;
    rd_src_r <= esrc_mem[eidx_r[EI_W-1:0]];
    rd_dst_r <= edst_mem[eidx_r[EI_W-1:0]];
    rd_len_r <= elen_mem[eidx_r[EI_W-1:0]];
    rd_fac_r <= fac_mem[fidx_r[FI_W-1:0]];
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    rd_dist_r <= dist_mem[dist_raddr];
  end

  // relax sum, shared adder
  dist_t relax_d;
  assign relax_d = curd_r + dist_t'(rd_len_r);

  logic [NI_W-1:0] scan_i, dst_i, fac_i;
  assign scan_i = scan_r[NI_W-1:0];
  assign dst_i  = rd_dst_r[NI_W-1:0];
  assign fac_i  = rd_fac_r[NI_W-1:0];

  always_comb begin
    dist_raddr = scan_i;
    dist_we    = 1'b0;
    dist_waddr = dst_i;
    dist_wdata = relax_d;
    unique case (state_r)
      S_EDGE, S_RELX: dist_raddr = dst_i;
      S_FAC, S_DREQ:  dist_raddr = (kind_r == KIND_DIST) ? b_r[NI_W-1:0] : fac_i;
      S_PICK:         dist_raddr = cur_r;
      default:        dist_raddr = scan_i;
    endcase
    if (state_r == S_INIT) begin
      dist_we = 1'b1; dist_waddr = a_r[NI_W-1:0]; dist_wdata = '0;
    end else if (state_r == S_RELX) begin
      dist_we = (rd_src_r == NODE_W'(cur_r)) && ({1'b0, rd_dst_r} < 7'(n_r))
                && !settled_r[dst_i]
                && (!reached_r[dst_i] || relax_d < rd_dist_r);
      dist_waddr = dst_i; dist_wdata = relax_d;
    end
  end

  logic [LEN_W-1:0] clip_best;
  assign clip_best = (best_r > dist_t'(LEN_MAX)) ? LEN_MAX : best_r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; node_count_r <= CNT_W'(64);
      edges_r <= '0; facs_r <= '0; dropped_r <= 1'b0;
      out_valid_r <= 1'b0; reached_r <= '0; settled_r <= '0;
      eidx_r <= '0; fidx_r <= '0; scan_r <= '0;
    end else begin
      if (done_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) node_count_r <= cfg_data[CNT_W-1:0];
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          kind_r <= in_kind; a_r <= in_a; b_r <= in_b; n_r <= n_act;
          o_node_r <= (in_kind == KIND_DIST) ? in_b : '0;
          o_len_r <= '0; best_node_r <= '0;
          case (in_kind)
            KIND_CLEAR: begin edges_r <= '0; facs_r <= '0; dropped_r <= 1'b0; end
            KIND_EDGE: begin
              if (edges_r < EC_W'(EDGE_LIMIT)) edges_r <= edges_r + 1'b1;
              else dropped_r <= 1'b1;
            end
            KIND_FAC: begin
              if (facs_r < FC_W'(FACILITY_LIMIT)) facs_r <= facs_r + 1'b1;
              else dropped_r <= 1'b1;
            end
            KIND_DIST, KIND_NEAREST: begin
              if ({1'b0, in_a} >= 7'(n_act) ||
                  (in_kind == KIND_DIST && {1'b0, in_b} >= 7'(n_act))) begin
                o_stat_r <= ST_RANGE; state_r <= S_DONE;
              end else if (in_kind == KIND_NEAREST && facs_r == '0) begin
                o_stat_r <= ST_UNREACH; state_r <= S_DONE;
              end else begin
                // only the start node is reached at first
                reached_r <= NODE_LIMIT'(1) << in_a[NI_W-1:0];
                settled_r <= '0;
                state_r <= S_INIT;
              end
            end
            default: ;
          endcase
        end
        S_INIT: begin scan_r <= '0; any_r <= 1'b0; state_r <= S_SCAN; end
        S_SCAN: begin
          // one node per cycle, read data is registered and arrives in the cycle after its address
          if (scan_r != '0) begin
            if (reached_r[NI_W'(scan_r - 1'b1)] && !settled_r[NI_W'(scan_r - 1'b1)]
                && (!any_r || rd_dist_r < best_r)) begin
              any_r <= 1'b1; cur_r <= NI_W'(scan_r - 1'b1); best_r <= rd_dist_r;
            end
          end
          if (scan_r == n_r) state_r <= S_PICK;
          else scan_r <= scan_r + 1'b1;
        end
        S_PICK: begin
          if (!any_r) begin
            fidx_r <= '0; state_r <= S_FREQ;
          end else begin
            settled_r[cur_r] <= 1'b1; curd_r <= best_r;
            eidx_r <= '0; state_r <= S_EREQ;
          end
        end
        S_EREQ: begin
          if (eidx_r == edges_r) begin scan_r <= '0; any_r <= 1'b0; state_r <= S_SCAN; end
          else state_r <= S_EDGE;
        end
        S_EDGE: state_r <= S_RELX;
        S_RELX: begin
          if (dist_we) reached_r[dst_i] <= 1'b1;
          eidx_r <= eidx_r + 1'b1; state_r <= S_EREQ;
        end
        S_FREQ: begin
          if (kind_r == KIND_DIST) state_r <= S_FAC;
          else if (fidx_r == facs_r) begin
            o_stat_r <= any_r ? ST_FOUND : ST_UNREACH;
            o_len_r <= any_r ? clip_best : '0;
            o_node_r <= best_node_r; state_r <= S_DONE;
          end else state_r <= S_FAC;
        end
        S_FAC: begin
          // fac read valid now, dist read next cycle
          state_r <= S_DREQ;
        end
        S_DREQ: begin
          if (kind_r == KIND_DIST) begin
            if (reached_r[b_r[NI_W-1:0]]) begin
              o_stat_r <= ST_FOUND;
              o_len_r <= (rd_dist_r > dist_t'(LEN_MAX)) ? LEN_MAX : rd_dist_r[LEN_W-1:0];
            end else o_stat_r <= ST_UNREACH;
            state_r <= S_DONE;
          end else begin
            if ({1'b0, rd_fac_r} < 7'(n_r) && reached_r[fac_i] &&
                (!any_r || rd_dist_r < best_r)) begin
              any_r <= 1'b1; best_r <= rd_dist_r; best_node_r <= rd_fac_r;
            end
            fidx_r <= fidx_r + 1'b1; state_r <= S_FREQ;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (done_go) begin
            out_stat_r <= o_stat_r; out_len_r <= o_len_r; out_node_r <= o_node_r;
            out_drop_r <= dropped_r; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_PICK && !any_r) any_r <= 1'b0;
    end
  end
endmodule
